// ===== hw/rtl/bcdclk_pkg.sv =====
// Shared types and constants for the BCD time-of-day clock.
package bcdclk_pkg;

  // Operation carried with each input word
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_KEY  = 1'b1;

  // Key codes acted on when a scan is taken
  localparam logic [5:0] KEY_HOUR_UP   = 6'b100010;
  localparam logic [5:0] KEY_HOUR_DOWN = 6'b100001;
  localparam logic [5:0] KEY_MIN_UP    = 6'b010010;
  localparam logic [5:0] KEY_MIN_DOWN  = 6'b010001;
  localparam logic [5:0] KEY_SEC_UP    = 6'b000110;
  localparam logic [5:0] KEY_SEC_DOWN  = 6'b000101;
  localparam logic [5:0] KEY_SEC_CLEAR = 6'b001000;

  localparam logic [15:0] RESET_PRESCALE = 16'd996;
  localparam int          HIST_DEPTH     = 3;
  localparam int          SEG_W          = 42;

  // Six BCD digits, seconds units in the low bits
  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] min_tens;
    logic [3:0] min_units;
    logic [2:0] sec_tens;
    logic [3:0] sec_units;
  } time_t;

  localparam time_t RESET_TIME = '{hour_tens: 2'd2, hour_units: 4'd3,
                                   min_tens: 3'd5, min_units: 4'd9,
                                   sec_tens: 3'd5, sec_units: 4'd0};

  // Per-word status flags
  typedef struct packed {
    logic key_taken;
    logic second_elapsed;
  } flags_t;

endpackage

// ===== hw/rtl/bcdclk_step.sv =====
// Next-state logic of the clock: prescaler, key debounce, BCD stepping, segments.
module bcdclk_step (
  input  logic                             op,
  input  logic [5:0]                       key,
  input  bcdclk_pkg::time_t                time_cur,
  input  logic [15:0]                      count_cur,
  input  logic [5:0]                       hist_cur [bcdclk_pkg::HIST_DEPTH],
  input  logic [15:0]                      reload,
  output bcdclk_pkg::time_t                time_next,
  output logic [15:0]                      count_next,
  output logic [5:0]                       hist_next [bcdclk_pkg::HIST_DEPTH],
  output bcdclk_pkg::flags_t               flags,
  output logic [bcdclk_pkg::SEG_W-1:0]     segments
);
  import bcdclk_pkg::*;

  typedef enum logic [1:0] {LVL_SEC, LVL_MIN, LVL_HOUR} level_t;

  // Increment starting at the given digit pair, carrying upward
  function automatic time_t inc_from(time_t t, level_t lvl);
    time_t r;
    logic  c;
    r = t;
    c = (lvl == LVL_SEC);
    if (c) begin
      if (r.sec_units == 4'd9) begin
        r.sec_units = 4'd0;
      end else begin
        r.sec_units = r.sec_units + 4'd1;
        c = 1'b0;
      end
    end
    if (c) begin
      if (r.sec_tens == 3'd5) begin
        r.sec_tens = 3'd0;
      end else begin
        r.sec_tens = r.sec_tens + 3'd1;
        c = 1'b0;
      end
    end
    c = c || (lvl == LVL_MIN);
    if (c) begin
      if (r.min_units == 4'd9) begin
        r.min_units = 4'd0;
      end else begin
        r.min_units = r.min_units + 4'd1;
        c = 1'b0;
      end
    end
    if (c) begin
      if (r.min_tens == 3'd5) begin
        r.min_tens = 3'd0;
      end else begin
        r.min_tens = r.min_tens + 3'd1;
        c = 1'b0;
      end
    end
    c = c || (lvl == LVL_HOUR);
    if (c) begin
      if (r.hour_tens == 2'd2 && r.hour_units == 4'd3) begin
        r.hour_tens  = 2'd0;
        r.hour_units = 4'd0;
      end else if (r.hour_units == 4'd9) begin
        r.hour_units = 4'd0;
        r.hour_tens  = r.hour_tens + 2'd1;
      end else begin
        r.hour_units = r.hour_units + 4'd1;
      end
    end
    return r;
  endfunction

  // Seven-segment pattern, bit 0 = segment a
  function automatic logic [6:0] seg7(logic [3:0] d);
    logic [6:0] p;
    case (d)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h07;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h6F;
      default: p = 7'h00;
    endcase
    return p;
  endfunction

  logic key_ok;

  // A scan is taken when it matches the two before it and not the third
  assign key_ok = (key == hist_cur[0]) && (key == hist_cur[1]) && (key != hist_cur[2]);

  always_comb begin
    time_next  = time_cur;
    count_next = count_cur;
    hist_next  = hist_cur;
    flags      = '0;
    if (op == OP_TICK) begin
      // prescaler: reload and advance one second when found at zero
      if (count_cur != 16'd0) begin
        count_next = count_cur - 16'd1;
      end else begin
        count_next           = reload;
        flags.second_elapsed = 1'b1;
        time_next            = inc_from(time_cur, LVL_SEC);
      end
    end else begin
      hist_next[0] = key;
      hist_next[1] = hist_cur[0];
      hist_next[2] = hist_cur[1];
      if (key_ok) begin
        flags.key_taken = 1'b1;
        case (key)
          KEY_HOUR_UP: time_next = inc_from(time_cur, LVL_HOUR);
          KEY_MIN_UP:  time_next = inc_from(time_cur, LVL_MIN);
          KEY_SEC_UP:  time_next = inc_from(time_cur, LVL_SEC);
          KEY_HOUR_DOWN: begin
            if (time_cur.hour_units == 4'd0) begin
              if (time_cur.hour_tens == 2'd0) begin
                time_next.hour_units = 4'd3;
                time_next.hour_tens  = 2'd2;
              end else begin
                time_next.hour_units = 4'd9;
                time_next.hour_tens  = time_cur.hour_tens - 2'd1;
              end
            end else begin
              time_next.hour_units = time_cur.hour_units - 4'd1;
            end
          end
          KEY_MIN_DOWN: begin
            if (time_cur.min_units == 4'd0) begin
              time_next.min_units = 4'd9;
              time_next.min_tens  = (time_cur.min_tens == 3'd0) ? 3'd5
                                                                : time_cur.min_tens - 3'd1;
            end else begin
              time_next.min_units = time_cur.min_units - 4'd1;
            end
          end
          KEY_SEC_DOWN: begin
            if (time_cur.sec_units == 4'd0) begin
              time_next.sec_units = 4'd9;
              time_next.sec_tens  = (time_cur.sec_tens == 3'd0) ? 3'd5
                                                                : time_cur.sec_tens - 3'd1;
            end else begin
              time_next.sec_units = time_cur.sec_units - 4'd1;
            end
          end
          KEY_SEC_CLEAR: begin
            time_next.sec_units = 4'd0;
            time_next.sec_tens  = 3'd0;
          end
          default: time_next = time_cur;
        endcase
      end
    end
  end

  // Segment patterns of the new time, seconds units lowest
  assign segments = {seg7({2'b00, time_next.hour_tens}),
                     seg7(time_next.hour_units),
                     seg7({1'b0, time_next.min_tens}),
                     seg7(time_next.min_units),
                     seg7({1'b0, time_next.sec_tens}),
                     seg7(time_next.sec_units)};

endmodule

// ===== hw/rtl/bcd_clock_with_key_set.sv =====
// 24-hour BCD time-of-day clock with prescaled ticks and debounced key setting.
//
// Each input word is either a timer tick (s_tuser = 0) or a key scan (s_tuser = 1)
// and yields exactly one output word with the six time digits, their packed
// seven-segment patterns, and second_elapsed / key_taken flags. Words pass an
// input register and an output register in turn before a result is presented,
// and one word is accepted every cycle as long as the output side keeps up; the
// clock state is updated by one short pass of BCD carry logic between those
// registers. The prescaler reload is written over the cfg port (reset 996, one
// second every reload + 1 ticks) and takes effect at the next reload; write it
// only while no words are in flight. Time resets to 23:59:50.
module bcd_clock_with_key_set (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [5:0] key_code, [7:6] zero
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // sec_units, sec_tens, min_units, min_tens,
                                 // hour_units, hour_tens, segments [61:20], zero
  output logic [1:0]  m_tuser,   // [0] second_elapsed, [1] key_taken
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // prescaler_reload
);
  import bcdclk_pkg::*;

  logic        adv;
  logic        in_valid;
  logic        in_op;
  logic [5:0]  in_key;

  time_t       time_q, time_next;
  logic [15:0] count, count_next;
  logic [5:0]  hist      [HIST_DEPTH];
  logic [5:0]  hist_next [HIST_DEPTH];
  logic [15:0] reload;
  flags_t      flags;
  logic [SEG_W-1:0] segments;

  time_t       out_time;
  flags_t      out_flags;
  logic [SEG_W-1:0] out_segments;

  // Output stage frees up when empty or being taken
  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = !in_valid || adv;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_op  <= s_tuser;
      in_key <= s_tdata[5:0];
    end
  end

  bcdclk_step u_step (
    .op        (in_op),
    .key       (in_key),
    .time_cur  (time_q),
    .count_cur (count),
    .hist_cur  (hist),
    .reload    (reload),
    .time_next (time_next),
    .count_next(count_next),
    .hist_next (hist_next),
    .flags     (flags),
    .segments  (segments)
  );

  // Clock state and reload register
  always_ff @(posedge clk) begin
    if (rst) begin
      time_q <= RESET_TIME;
      count  <= RESET_PRESCALE;
      reload <= RESET_PRESCALE;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        reload <= cfg_data;
      end
      if (in_valid && adv) begin
        time_q <= time_next;
        count  <= count_next;
        hist   <= hist_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid;
    end
    if (in_valid && adv) begin
      out_time     <= time_next;
      out_flags    <= flags;
      out_segments <= segments;
    end
  end

  assign m_tdata = {2'b00, out_segments,
                    out_time.hour_tens, out_time.hour_units,
                    out_time.min_tens, out_time.min_units,
                    out_time.sec_tens, out_time.sec_units};
  assign m_tuser = {out_flags.key_taken, out_flags.second_elapsed};

endmodule
